### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

### rtl/hse_pkg.sv
// Types, constants and character functions of the header sniff hex escape filter.
package hse_pkg;

   localparam int PROBE_DEPTH = 16;
   localparam int PROBE_AW    = $clog2(PROBE_DEPTH);
   localparam int COUNT_W     = $clog2(PROBE_DEPTH + 1);
   localparam int PHASE_W     = 2;

   localparam logic [7:0] CH_N         = 8'h4E;
   localparam logic [7:0] CH_M         = 8'h4D;
   localparam logic [7:0] CH_L         = 8'h4C;
   localparam logic [7:0] CH_S         = 8'h53;
   localparam logic [7:0] VER_ONE      = 8'd1;
   localparam logic [7:0] VER_TWO      = 8'd2;
   localparam logic [7:0] PRINT_LO     = 8'd32;
   localparam logic [7:0] PRINT_HI     = 8'd126;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_HEX_ALPHA = 8'h37;
   localparam logic [7:0] REJECT_CHAR  = 8'h00;

   // Character positions inside one escape sequence.
   localparam logic [PHASE_W-1:0] PH_SLASH = 2'd0;
   localparam logic [PHASE_W-1:0] PH_X     = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HI    = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LO    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ESC,
      ST_REJECT,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                en;
      logic [PROBE_AW-1:0] addr;
      logic [7:0]          data;
   } probe_wr_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       done;
   } char_out_type;

   function automatic logic passes_plain(input logic [7:0] b);
      return (b == CH_NL) || (b == CH_CR) || (b == CH_TAB) ||
             ((b >= PRINT_LO) && (b <= PRINT_HI));
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (CH_ZERO + {4'b0, nib}) : (CH_HEX_ALPHA + {4'b0, nib});
   endfunction

   // Checks one header byte against the magic at its position; later bytes pass.
   function automatic logic magic_step(input logic [COUNT_W-1:0] idx, input logic [7:0] b);
      logic ok;
      priority if (idx == COUNT_W'(0)) ok = (b == CH_N);
      else if (idx == COUNT_W'(1)) ok = (b == CH_M);
      else if (idx == COUNT_W'(2)) ok = (b == CH_L);
      else if (idx == COUNT_W'(3)) ok = (b == CH_S);
      else if (idx == COUNT_W'(4)) ok = (b == VER_ONE) || (b == VER_TWO);
      else ok = 1'b1;
      return ok;
   endfunction

endpackage

### rtl/hse_probe_store.sv
// Probe store holding the first bytes of a file, with a registered read port.
module hse_probe_store (
   input  logic                         clock,
   input  hse_pkg::probe_wr_type        wr,
   input  logic [hse_pkg::PROBE_AW-1:0] rd_addr,
   output logic [7:0]                   rd_data
);
   import hse_pkg::*;

   logic [7:0] mem [PROBE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hse_char_unit.sv
// Shared unit that gives one output character of a byte's escaped form per call.
module hse_char_unit (
   input  logic [7:0]                  data_in,
   input  logic [hse_pkg::PHASE_W-1:0] phase,
   output hse_pkg::char_out_type       res
);
   import hse_pkg::*;

   always_comb begin
      if (passes_plain(data_in)) begin
         res.ch   = data_in;
         res.done = 1'b1;
      end else begin
         res.done = (phase == PH_LO);
         unique case (phase)
            PH_SLASH: res.ch = CH_BACKSLASH;
            PH_X:     res.ch = CH_LOWER_X;
            PH_HI:    res.ch = hex_char(data_in[7:4]);
            PH_LO:    res.ch = hex_char(data_in[3:0]);
            default:  res.ch = CH_BACKSLASH;
         endcase
      end
   end

endmodule

### rtl/header_sniff_hex_escape_filter.sv
// Use: bytes of one file enter on the req_ channel, one transfer each, with req_tlast
// on the final byte. The first 16 bytes are held back in a probe store. If they start
// with the archive magic and a version of 1 or 2, one reject transfer (rsp_tuser high,
// data zero) is sent and the rest of the file is dropped. Otherwise the held bytes and
// every later byte come out as text on the rsp_ channel, one character per transfer,
// with non-printable bytes written as a backslash, x and two upper-case hex digits;
// tab, line feed and carriage return pass as they are. rsp_tlast marks the reject,
// the last character of the probe flush and the last character of each later byte.
// A later byte gives its output characters (one or four) one per cycle while the
// receiver is ready, from the single character unit. The flush of the probe reads
// each held byte from the store and then sends its one to four characters.
// Bytes that only fill the probe, and bytes of a refused file, produce no output.
// req_tready is high only while idle. A stalled receiver holds the output register
// and with it the whole sequence. Reset (synchronous) empties the probe and starts
// a fresh file; each file's final byte does the same once its output has been sent.
module header_sniff_hex_escape_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // file_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tuser,   // [0] rejected
   output logic       rsp_tlast    // run_last
);
   import hse_pkg::*;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 decided_ff, decided_in;
   logic                 refused_ff, refused_in;
   logic                 magic_ok_ff, magic_ok_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [PROBE_AW-1:0]  rd_idx_ff, rd_idx_in;
   logic                 last_ff, last_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept, probing, full_now, magic_now, file_clear;
   logic                 out_free, emit, emit_rej, emit_last, flush_end;
   logic [7:0]           emit_ch, cu_data, rd_data;
   char_out_type         cu_res;
   probe_wr_type         probe_wr;

   assign accept    = req_tvalid && req_tready;
   assign probing   = !refused_ff && !decided_ff;
   assign full_now  = (count_ff == COUNT_W'(PROBE_DEPTH - 1));
   assign magic_now = magic_ok_ff && magic_step(count_ff, req_tdata);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign flush_end = ((COUNT_W'(rd_idx_ff) + COUNT_W'(1)) == count_ff);

   assign probe_wr.en   = accept && probing;
   assign probe_wr.addr = count_ff[PROBE_AW-1:0];
   assign probe_wr.data = req_tdata;

   hse_probe_store u_probe (
      .clock   (clock),
      .wr      (probe_wr),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign cu_data = (state_ff == ST_EMIT) ? rd_data : byte_ff;

   hse_char_unit u_char (
      .data_in (cu_data),
      .phase   (phase_ff),
      .res     (cu_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (refused_ff) state_in = ST_IDLE;
               else if (decided_ff) state_in = ST_ESC;
               else if (full_now) state_in = magic_now ? ST_REJECT : ST_LOAD;
               else if (req_tlast) state_in = ST_LOAD;
               else state_in = ST_IDLE;
            end
         end
         ST_ESC: begin
            if (emit && emit_last) state_in = ST_IDLE;
         end
         ST_REJECT: begin
            if (emit) state_in = ST_IDLE;
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit && cu_res.done) state_in = flush_end ? ST_IDLE : ST_LOAD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      emit       = 1'b0;
      emit_ch    = cu_res.ch;
      emit_rej   = 1'b0;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_ESC: begin
            emit      = out_free;
            emit_last = cu_res.done;
         end
         ST_REJECT: begin
            emit      = out_free;
            emit_ch   = REJECT_CHAR;
            emit_rej  = 1'b1;
            emit_last = 1'b1;
         end
         ST_LOAD: begin
            emit = 1'b0;
         end
         ST_EMIT: begin
            emit      = out_free;
            emit_last = cu_res.done && flush_end;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // A file ends either when its final byte is dropped or when the last result
   // caused by its final byte is sent.
   assign file_clear = (accept && refused_ff && req_tlast) ||
                       (emit && emit_last && last_ff);

   always_comb begin
      count_in    = count_ff;
      decided_in  = decided_ff;
      refused_in  = refused_ff;
      magic_ok_in = magic_ok_ff;
      if (file_clear) begin
         count_in    = '0;
         decided_in  = 1'b0;
         refused_in  = 1'b0;
         magic_ok_in = 1'b1;
      end else if (accept && probing) begin
         count_in    = count_ff + COUNT_W'(1);
         magic_ok_in = magic_now;
         if (full_now) begin
            decided_in = !magic_now;
            refused_in = magic_now;
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      rd_idx_in = rd_idx_ff;
      if (accept) begin
         phase_in  = '0;
         rd_idx_in = '0;
      end else if (emit) begin
         phase_in = cu_res.done ? '0 : phase_ff + PHASE_W'(1);
         if (cu_res.done && (state_ff == ST_EMIT) && !flush_end) begin
            rd_idx_in = rd_idx_ff + PROBE_AW'(1);
         end
      end
   end

   assign last_in = accept ? req_tlast : last_ff;
   assign byte_in = accept ? req_tdata : byte_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_ch;
         rsp_user_in  = emit_rej;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         decided_ff   <= 1'b0;
         refused_ff   <= 1'b0;
         magic_ok_ff  <= 1'b1;
         phase_ff     <= '0;
         rd_idx_ff    <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         decided_ff   <= decided_in;
         refused_ff   <= refused_in;
         magic_ok_ff  <= magic_ok_in;
         phase_ff     <= phase_in;
         rd_idx_ff    <= rd_idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/hse_checker.sv
// Port-level checks of the header sniff hex escape filter, bound to the top level.
`include "assert_macros.svh"

module hse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result transfer keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // A reject is a single zero character that closes its run.
   `ASSERT_SAME(a_reject_form, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata == 8'h00) && rsp_tlast)

   // While the run of an input byte is still going, no new byte is taken.
   `ASSERT_SAME(a_busy_in_run, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // Reset leaves no result pending.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind header_sniff_hex_escape_filter hse_checker u_hse_checker (.*);
